/* design/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// Depends on nothing; used by the cell and the top level.
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } req_t;

    // Control broadcast to every cell for the current transaction.
    typedef struct packed {
        logic enq;  // accepted enqueue with room left
        logic deq;  // accepted dequeue on a non-empty queue
    } cell_ctrl_t;

endpackage

/* design/spq_cell.sv */
// One slot of the shift-register priority queue.
// Depends on spq_pkg; instantiated DEPTH times by sorted_priority_queue_top.
module spq_cell (
    input  logic                                clk,
    input  spq_pkg::cell_ctrl_t                 ctrl,
    input  logic                                occupied,
    input  logic signed [spq_pkg::VALUE_W-1:0]  new_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   new_prio,
    input  logic                                left_ge,
    input  logic signed [spq_pkg::VALUE_W-1:0]  left_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   left_prio,
    input  logic signed [spq_pkg::VALUE_W-1:0]  right_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   right_prio,
    output logic                                ge,
    output logic signed [spq_pkg::VALUE_W-1:0]  value,
    output logic signed [spq_pkg::PRIO_W-1:0]   prio
);

    logic signed [spq_pkg::VALUE_W-1:0] value_reg;
    logic signed [spq_pkg::VALUE_W-1:0] value_next;
    logic signed [spq_pkg::PRIO_W-1:0]  prio_reg;
    logic signed [spq_pkg::PRIO_W-1:0]  prio_next;

    // A held entry at or above the new priority stays ahead of the new one.
    assign ge = occupied && (prio_reg >= new_prio);

    // Keep, take the new entry, shift down from the left, or shift up from the right.
    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.enq && !ge) begin
            if (left_ge) begin
                value_next = new_value;
                prio_next  = new_prio;
            end else begin
                value_next = left_value;
                prio_next  = left_prio;
            end
        end else if (ctrl.deq) begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    // Entry storage carries no reset; only slots below the count are read.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

/* design/sorted_priority_queue_top.sv */
// Sorted priority queue built as a chain of compare-and-shift cells.
// Results are registered: a result appears in the cycle after its transaction is accepted.
// Throughput: one enqueue or dequeue per cycle while each result is taken at once;
// a held result stalls the input until it is taken.
// Reset (rst_n, asynchronous, active low) empties the queue and marks the result register
// empty. Depends on spq_pkg and spq_cell.
module sorted_priority_queue_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic signed [spq_pkg::VALUE_W-1:0]  item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   item_priority,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic signed [spq_pkg::VALUE_W-1:0]  out_value,
    output logic signed [spq_pkg::PRIO_W-1:0]   out_priority,
    output logic [spq_pkg::COUNT_W-1:0]         count
);

    localparam int D = spq_pkg::DEPTH;

    logic [spq_pkg::CNT_W-1:0]          count_reg;
    logic [spq_pkg::CNT_W-1:0]          count_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    spq_pkg::status_t                   status_reg;
    spq_pkg::status_t                   status_next;
    logic signed [spq_pkg::VALUE_W-1:0] out_value_reg;
    logic signed [spq_pkg::VALUE_W-1:0] out_value_next;
    logic signed [spq_pkg::PRIO_W-1:0]  out_prio_reg;
    logic signed [spq_pkg::PRIO_W-1:0]  out_prio_next;

    logic                               accept;
    logic                               is_full;
    logic                               is_empty;
    spq_pkg::cell_ctrl_t                ctrl;

    logic [D-1:0]                       occ_vec;
    logic [D-1:0]                       ge_vec;
    logic signed [spq_pkg::VALUE_W-1:0] cell_value [D];
    logic signed [spq_pkg::PRIO_W-1:0]  cell_prio [D];

    // The input is taken whenever the result register is free or being drained.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_full  = (count_reg == spq_pkg::CNT_W'(D));
    assign is_empty = (count_reg == '0);

    assign ctrl.enq = accept && (req_type == spq_pkg::REQ_ENQ) && !is_full;
    assign ctrl.deq = accept && (req_type == spq_pkg::REQ_DEQ) && !is_empty;

    // Cell chain: each cell sees its neighbors' entries and compare flags.
    genvar gi;
    generate
        for (gi = 0; gi < D; gi++) begin : g_cell
            logic                               l_ge;
            logic signed [spq_pkg::VALUE_W-1:0] l_value;
            logic signed [spq_pkg::PRIO_W-1:0]  l_prio;
            logic signed [spq_pkg::VALUE_W-1:0] r_value;
            logic signed [spq_pkg::PRIO_W-1:0]  r_prio;

            assign occ_vec[gi] = (spq_pkg::CNT_W'(gi) < count_reg);

            if (gi == 0) begin : g_head
                assign l_ge    = 1'b1;
                assign l_value = item_value;
                assign l_prio  = item_priority;
            end else begin : g_body
                assign l_ge    = ge_vec[gi-1];
                assign l_value = cell_value[gi-1];
                assign l_prio  = cell_prio[gi-1];
            end

            if (gi == D - 1) begin : g_tail
                assign r_value = cell_value[gi];
                assign r_prio  = cell_prio[gi];
            end else begin : g_inner
                assign r_value = cell_value[gi+1];
                assign r_prio  = cell_prio[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occ_vec[gi]),
                .new_value   (item_value),
                .new_prio    (item_priority),
                .left_ge     (l_ge),
                .left_value  (l_value),
                .left_prio   (l_prio),
                .right_value (r_value),
                .right_prio  (r_prio),
                .ge          (ge_vec[gi]),
                .value       (cell_value[gi]),
                .prio        (cell_prio[gi])
            );
        end
    endgenerate

    // Count update and result formation for the accepted transaction.
    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        out_value_next = out_value_reg;
        out_prio_next  = out_prio_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (accept) begin
            out_valid_next = 1'b1;
            status_next    = spq_pkg::ST_DONE;
            out_value_next = '0;
            out_prio_next  = '0;
            if (req_type == spq_pkg::REQ_ENQ) begin
                if (is_full) begin
                    status_next = spq_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + spq_pkg::CNT_W'(1);
                end
            end else begin
                if (is_empty) begin
                    status_next    = spq_pkg::ST_EMPTY;
                    out_value_next = '1;
                    out_prio_next  = '1;
                end else begin
                    out_value_next = cell_value[0];
                    out_prio_next  = cell_prio[0];
                    count_next     = count_reg - spq_pkg::CNT_W'(1);
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        out_value_reg <= out_value_next;
        out_prio_reg  <= out_prio_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_value    = out_value_reg;
    assign out_priority = out_prio_reg;
    assign count        = spq_pkg::COUNT_W'(count_reg);

`ifndef SYNTHESIS
    // The count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::CNT_W'(D))
        else $error("queue count exceeds capacity");

    // An enqueue with room grows the count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.enq |=> (count_reg == $past(count_reg) + spq_pkg::CNT_W'(1)))
        else $error("enqueue did not grow the count");

    // A dequeue on an empty queue reports the empty status next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == spq_pkg::REQ_DEQ) && is_empty)
        |=> (out_valid_reg && (status_reg == spq_pkg::ST_EMPTY)))
        else $error("empty dequeue not reported");

    // The two front entries stay in descending priority order.
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_vec[1] |-> (cell_prio[0] >= cell_prio[1]))
        else $error("head entries out of priority order");
`endif

endmodule
